/* hdl/mrfc_pkg.sv */
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types, constants and the crc-16/modbus byte update for the checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  localparam int unsigned PosW     = 3;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = 1;
  localparam int unsigned QLvlW    = 2;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [CfgIdxW-1:0] RegStationAddress = 8'd0;
  localparam logic [CfgIdxW-1:0] RegFunctionCode   = 8'd1;

  localparam logic [7:0]  StationAddressReset = 8'h01;
  localparam logic [7:0]  FunctionCodeReset   = 8'h03;
  localparam logic [15:0] CrcInit             = 16'hFFFF;

  typedef struct packed {
    logic [7:0]      data;
    logic [PosW-1:0] pos;
  } entry_t;

  function automatic logic [15:0] crc_nibble(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'h0:    v = 16'h0000;
      4'h1:    v = 16'hCC01;
      4'h2:    v = 16'hD801;
      4'h3:    v = 16'h1400;
      4'h4:    v = 16'hF001;
      4'h5:    v = 16'h3C00;
      4'h6:    v = 16'h2800;
      4'h7:    v = 16'hE401;
      4'h8:    v = 16'hA001;
      4'h9:    v = 16'h6C00;
      4'hA:    v = 16'h7800;
      4'hB:    v = 16'hB401;
      4'hC:    v = 16'h5000;
      4'hD:    v = 16'h9C01;
      4'hE:    v = 16'h8801;
      default: v = 16'h4400;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c1;
    logic [15:0] c2;
    c1 = crc_nibble(b[3:0] ^ crc[3:0]) ^ {4'h0, crc[15:4]};
    c2 = crc_nibble(b[7:4] ^ c1[3:0]) ^ {4'h0, c1[15:4]};
    return c2;
  endfunction

endpackage

/* hdl/mrfc_front.sv */
// ----------------------------------------------------------------------------
// mrfc_front
// Holds the header registers, frames incoming bytes and tags each kept byte
// with its position in the frame.
// ----------------------------------------------------------------------------
module mrfc_front import mrfc_pkg::*; #(
  parameter int unsigned FRAME_LENGTH = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic [7:0]         rx_byte,
  input  logic               q_full,
  output logic               in_ready,
  output logic               push,
  output entry_t             push_entry,
  output logic [PosW-1:0]    byte_count
);

  logic [7:0]      station_address;
  logic [7:0]      function_code;
  logic [PosW-1:0] byte_count_next;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= StationAddressReset;
      function_code   <= FunctionCodeReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegStationAddress) begin
        station_address <= cfg_data;
      end else if (cfg_index == RegFunctionCode) begin
        function_code <= cfg_data;
      end
    end
  end

  always_comb begin
    byte_count_next = byte_count;
    push            = 1'b0;
    push_entry.data = rx_byte;
    push_entry.pos  = byte_count;
    if (accept) begin
      if (byte_count == PosW'(0)) begin
        if (rx_byte == station_address) begin
          push            = 1'b1;
          byte_count_next = PosW'(1);
        end
      end else if (byte_count == PosW'(1) && rx_byte != function_code) begin
        // resync on a repeated address byte
        if (rx_byte == station_address) begin
          push            = 1'b1;
          push_entry.pos  = PosW'(0);
          byte_count_next = PosW'(1);
        end else begin
          byte_count_next = PosW'(0);
        end
      end else begin
        push = 1'b1;
        if (byte_count == PosW'(FRAME_LENGTH - 1)) begin
          byte_count_next = PosW'(0);
        end else begin
          byte_count_next = byte_count + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

endmodule

/* hdl/mrfc_queue.sv */
// ----------------------------------------------------------------------------
// mrfc_queue
// Two-entry queue of tagged frame bytes between the framer and the crc stage.
// ----------------------------------------------------------------------------
module mrfc_queue import mrfc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  entry_t           push_entry,
  input  logic             pop,
  output logic             q_full,
  output logic             q_valid,
  output entry_t           head,
  output logic [QLvlW-1:0] level
);

  entry_t            slots [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;

  assign q_full  = (level == QLvlW'(QDepth));
  assign q_valid = (level != '0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      case ({push, pop})
        2'b10:   level <= level + QLvlW'(1);
        2'b01:   level <= level - QLvlW'(1);
        default: level <= level;
      endcase
    end
  end

endmodule

/* hdl/mrfc_back.sv */
// ----------------------------------------------------------------------------
// mrfc_back
// Runs the crc over queued frame bytes, captures the register value and
// presents one result beat per frame from an output register.
// ----------------------------------------------------------------------------
module mrfc_back import mrfc_pkg::*; #(
  parameter int unsigned FRAME_LENGTH = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        crc_ok,
  output logic [15:0] register_value,
  output logic        status_flag
);

  logic [15:0] crc_reg;
  logic [15:0] crc_next;
  logic [15:0] value_hold;
  logic [15:0] value_next;
  logic        flag_hold;
  logic        flag_next;
  logic        last;
  logic        good;
  logic        slot_free;

  assign last      = (head.pos == PosW'(FRAME_LENGTH - 1));
  assign slot_free = !out_valid || out_ready;
  assign pop       = q_valid && (!last || slot_free);

  always_comb begin
    crc_next   = crc_byte((head.pos == PosW'(0)) ? CrcInit : crc_reg, head.data);
    value_next = value_hold;
    if (head.pos == PosW'(3)) begin
      value_next[15:8] = head.data;
    end else if (head.pos == PosW'(4)) begin
      value_next[7:0] = head.data;
    end
    good      = (crc_next == 16'h0000);
    flag_next = good ? (value_next[7:0] == 8'h01) : flag_hold;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      crc_reg    <= crc_next;
      value_hold <= value_next;
    end
    if (pop && last) begin
      crc_ok         <= good;
      register_value <= value_next;
      status_flag    <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_hold <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && last) begin
        flag_hold <= flag_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/modbus_response_frame_checker.sv */
// ----------------------------------------------------------------------------
// modbus_response_frame_checker
// Frames fixed-length modbus rtu responses, checks crc-16/modbus and reports
// the register value and a held status flag per frame.
//
//   channel  signals                                   dir  beat
//   cfg      cfg_valid cfg_ready cfg_index cfg_data    in   one register write
//   in       in_valid in_ready rx_byte                 in   one received byte
//   out      out_valid out_ready crc_ok                out  one frame result
//            register_value status_flag
//
// one byte per cycle sustained; a result is registered when the crc stage
// pops the last byte of its frame from the queue. the framer sets the pace,
// the crc stage takes one byte a cycle from a two-entry queue. reset clears
// framing, queue, held flag and loads header registers with 1 and 3. a
// stalled result stalls the crc stage only on the last byte of the next
// frame; the input stalls when the queue is full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module modbus_response_frame_checker import mrfc_pkg::*; #(
  parameter int unsigned FRAME_LENGTH = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               crc_ok,
  output logic [15:0]        register_value,
  output logic               status_flag
);

  logic             push;
  entry_t           push_entry;
  logic             pop;
  logic             q_full;
  logic             q_valid;
  entry_t           head;
  logic [QLvlW-1:0] level;
  logic [PosW-1:0]  byte_count;

  assign cfg_ready = 1'b1;

  mrfc_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .rx_byte    (rx_byte),
    .q_full     (q_full),
    .in_ready   (in_ready),
    .push       (push),
    .push_entry (push_entry),
    .byte_count (byte_count)
  );

  mrfc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_full     (q_full),
    .q_valid    (q_valid),
    .head       (head),
    .level      (level)
  );

  mrfc_back #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .crc_ok         (crc_ok),
    .register_value (register_value),
    .status_flag    (status_flag)
  );

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= QLvlW'(QDepth))
    else $error("queue level beyond depth");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count < PosW'(FRAME_LENGTH))
    else $error("frame byte count out of range");

  a_bad_crc_holds_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !crc_ok |-> status_flag == $past(u_back.flag_hold))
    else $error("status flag changed on bad crc");
`endif

endmodule
